// ===== rtl/core/sprite_run_length_decoder_core_defines.svh =====
// assertion macros for the sprite run-length decoder core
// expects clk and rst_n in the scope of each use
`ifndef SPRITE_RUN_LENGTH_DECODER_CORE_DEFINES_SVH
`define SPRITE_RUN_LENGTH_DECODER_CORE_DEFINES_SVH

// same-cycle implication
`define SRLD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SRLD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/srld_pkg.sv =====
// shared types and codes for the sprite run-length decoder
// no dependencies
`default_nettype none

package srld_pkg;

    localparam int unsigned DATA_W  = 8;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned LEFT_W  = 7;
    localparam int unsigned FILL_W  = 6;

    localparam logic [DATA_W-1:0] COPY_MAX = 8'd65;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_ZERO_HDR = 2'd1,
        STATUS_CUT      = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_COPY   = 3'b010,
        PH_FILL   = 3'b100
    } phase_t;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              frame_last;
    } byte_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] run_count;
        logic [DATA_W-1:0]  pixel_index;
        logic               transparent;
        logic               frame_end;
        status_t            status;
    } run_item_t;

    typedef struct packed {
        logic in_header;
        logic err_seen;
    } dec_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/srld_ifs.sv =====
// valid/ready channel interfaces for encoded bytes and decoded runs
// no dependencies
`default_nettype none

interface srld_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_last;

    modport source (output valid, output data_byte, output frame_last, input ready);
    modport sink   (input valid, input data_byte, input frame_last, output ready);
endinterface

interface srld_run_if;
    logic       valid;
    logic       ready;
    logic [7:0] run_count;
    logic [7:0] pixel_index;
    logic       transparent;
    logic       frame_end;
    logic [1:0] status;

    modport source (output valid, output run_count, output pixel_index,
                    output transparent, output frame_end, output status, input ready);
    modport sink   (input valid, input run_count, input pixel_index,
                    input transparent, input frame_end, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/srld_in_stage.sv =====
// input register stage holding one encoded byte
// depends on srld_pkg
`default_nettype none

module srld_in_stage
    import srld_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       src_valid,
    input  wire byte_item_t src_item,
    output logic            src_ready,
    input  wire logic       advance,
    output logic            item_valid,
    output byte_item_t      item
);

    logic       vld_reg;
    logic       vld_next;
    byte_item_t item_reg;
    logic       load;

    assign src_ready = !vld_reg || advance;
    assign load      = src_valid && src_ready;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (advance)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= src_item;
        end
    end

    assign item_valid = vld_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== rtl/core/srld_decode.sv =====
// frame parser: header decode, copy and fill tracking, error and frame-end status
// depends on srld_pkg
`default_nettype none

module srld_decode
    import srld_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       format_sel,
    input  wire logic       fire,
    input  wire byte_item_t item,
    output run_item_t       res,
    output logic            has_res,
    output dec_stat_t       stat
);

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [LEFT_W-1:0] left_reg;
    logic [LEFT_W-1:0] left_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    status_t           err_reg;
    status_t           err_next;

    logic [DATA_W-1:0]  b;
    logic [DATA_W-1:0]  neg_b;
    logic [DATA_W-1:0]  fill_len;
    logic [LEFT_W-1:0]  left_dec;
    logic               have;
    logic [COUNT_W-1:0] cnt;
    logic [DATA_W-1:0]  idx;
    logic               tr;
    status_t            st;

    assign b        = item.data_byte;
    assign neg_b    = DATA_W'(9'd256 - {1'b0, b});
    assign fill_len = neg_b - COPY_MAX;
    assign left_dec = left_reg - LEFT_W'(1);

    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        fill_next  = fill_reg;
        err_next   = err_reg;
        have       = 1'b0;
        cnt        = '0;
        idx        = '0;
        tr         = 1'b0;
        if (err_reg == STATUS_OK)
        begin
            unique case (phase_reg)
                PH_COPY:
                begin
                    cnt       = COUNT_W'(1);
                    idx       = b;
                    have      = 1'b1;
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        phase_next = PH_HEADER;
                    end
                end
                PH_FILL:
                begin
                    cnt        = COUNT_W'(fill_reg);
                    idx        = b;
                    have       = 1'b1;
                    fill_next  = '0;
                    phase_next = PH_HEADER;
                end
                default:
                begin
                    phase_next = PH_HEADER;
                    if (!format_sel)
                    begin
                        if (b[DATA_W-1])
                        begin
                            cnt  = neg_b;
                            tr   = 1'b1;
                            have = 1'b1;
                        end
                        else if (b != '0)
                        begin
                            left_next  = b[LEFT_W-1:0];
                            phase_next = PH_COPY;
                        end
                    end
                    else
                    begin
                        if (b == '0)
                        begin
                            err_next = STATUS_ZERO_HDR;
                        end
                        else if (!b[DATA_W-1])
                        begin
                            cnt  = b;
                            tr   = 1'b1;
                            have = 1'b1;
                        end
                        else if (neg_b <= COPY_MAX)
                        begin
                            left_next  = neg_b[LEFT_W-1:0];
                            phase_next = PH_COPY;
                        end
                        else
                        begin
                            fill_next  = fill_len[FILL_W-1:0];
                            phase_next = PH_FILL;
                        end
                    end
                end
            endcase
        end

        st = err_next;
        if (st == STATUS_OK && phase_next != PH_HEADER)
        begin
            st = STATUS_CUT;
        end

        res.run_count   = cnt;
        res.pixel_index = idx;
        res.transparent = tr;
        res.frame_end   = 1'b0;
        res.status      = STATUS_OK;
        has_res         = have;

        if (item.frame_last)
        begin
            // frame end always reports, runs dropped on a bad frame
            has_res       = 1'b1;
            res.frame_end = 1'b1;
            res.status    = st;
            if (st != STATUS_OK)
            begin
                res.run_count   = '0;
                res.pixel_index = '0;
                res.transparent = 1'b0;
            end
            phase_next = PH_HEADER;
            left_next  = '0;
            fill_next  = '0;
            err_next   = STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            left_reg  <= '0;
            fill_reg  <= '0;
            err_reg   <= STATUS_OK;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            fill_reg  <= fill_next;
            err_reg   <= err_next;
        end
    end

    assign stat.in_header = (phase_reg == PH_HEADER);
    assign stat.err_seen  = (err_reg != STATUS_OK);

endmodule

`default_nettype wire

// ===== rtl/core/srld_out_stage.sv =====
// result register toward the run channel
// depends on srld_pkg
`default_nettype none

module srld_out_stage
    import srld_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      load,
    input  wire run_item_t res,
    input  wire logic      dst_ready,
    output logic           dst_valid,
    output run_item_t      dst_item,
    output logic           free
);

    logic      vld_reg;
    logic      vld_next;
    run_item_t res_reg;

    assign free = !vld_reg || dst_ready;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (dst_ready)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign dst_valid = vld_reg;
    assign dst_item  = res_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sprite_run_length_decoder_core.sv =====
// sprite run-length decoder core: one encoded byte in, at most one run out
// path: a byte is held in the input register, parsed combinationally, then its run is held in the result register
// throughput: one byte per cycle unless a run waits in the result register on runs.ready
// reset: rst_n clears the parser state, format register and both stage valids
// depends on srld_pkg, srld_ifs, srld_in_stage, srld_decode, srld_out_stage, defines header
`default_nettype none
`include "sprite_run_length_decoder_core_defines.svh"

module sprite_run_length_decoder_core
    import srld_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    format_we,
    input  wire logic    format_wdata,
    srld_byte_if.sink    stream,
    srld_run_if.source   runs
);

    logic       format_reg;
    byte_item_t src_item;
    byte_item_t item;
    logic       item_valid;
    logic       advance;
    run_item_t  res;
    logic       has_res;
    dec_stat_t  stat;
    logic       out_free;
    run_item_t  out_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= 1'b0;
        end
        else if (format_we)
        begin
            format_reg <= format_wdata;
        end
    end

    assign src_item.data_byte  = stream.data_byte;
    assign src_item.frame_last = stream.frame_last;

    assign advance = item_valid && (!has_res || out_free);

    srld_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (stream.valid),
        .src_item   (src_item),
        .src_ready  (stream.ready),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    srld_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .format_sel (format_reg),
        .fire       (advance),
        .item       (item),
        .res        (res),
        .has_res    (has_res),
        .stat       (stat)
    );

    srld_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && has_res),
        .res       (res),
        .dst_ready (runs.ready),
        .dst_valid (runs.valid),
        .dst_item  (out_item),
        .free      (out_free)
    );

    assign runs.run_count   = out_item.run_count;
    assign runs.pixel_index = out_item.pixel_index;
    assign runs.transparent = out_item.transparent;
    assign runs.frame_end   = out_item.frame_end;
    assign runs.status      = out_item.status;

    `SRLD_ASSERT_NOW(a_status_on_end, runs.valid && (runs.status != STATUS_OK), runs.frame_end, "status without frame end")
    `SRLD_ASSERT_NOW(a_status_only, runs.valid && (runs.status != STATUS_OK), (runs.run_count == '0) && !runs.transparent, "bad frame carries a run")
    `SRLD_ASSERT_NOW(a_transp_index, runs.valid && runs.transparent, runs.pixel_index == '0, "transparent run with index")
    `SRLD_ASSERT_NEXT(a_frame_clear, advance && item.frame_last, stat.in_header && !stat.err_seen, "parser not cleared after frame end")

endmodule

`default_nettype wire
